FILE: hdl/bbc_pkg.sv
// shared types, register indexes and the world edge saturation for the mask box collider
package bbc_pkg;

  localparam int DIM_W   = 13;
  localparam int LOC_W   = 11;
  localparam int SCALE_W = 24;
  localparam int POS_W   = 16;
  localparam int WORLD_W = 21;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 24;
  localparam int PROD_W  = DIM_W + SCALE_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic [IDX_W-1:0] REG_MASK_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MASK_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE_X      = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE_Y      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COLLISION_ON = 3'd4;
  localparam logic [IDX_W-1:0] REG_POS_X        = 3'd5;
  localparam logic [IDX_W-1:0] REG_POS_Y        = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y1;
    logic [DIM_W-1:0] x2;
    logic [DIM_W-1:0] y2;
  } box_t;

  typedef struct packed {
    logic [SCALE_W-1:0]      scale_x;
    logic [SCALE_W-1:0]      scale_y;
    logic                    collision_on;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } cfg_t;

  function automatic logic signed [WORLD_W-1:0] sat_world(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (WORLD_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[WORLD_W-1:0];
    end else if (v < lo) begin
      return lo[WORLD_W-1:0];
    end
    return v[WORLD_W-1:0];
  endfunction

endpackage

FILE: hdl/bbc_front.sv
// pixel scanner: tracks the set-pixel extent and emits the local box at frame end
module bbc_front import bbc_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic [LOC_W-1:0] mask_width,
  input  logic [LOC_W-1:0] mask_height,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  logic             pixel_set,
  input  logic             full,
  output logic             push,
  output box_t             box
);

  localparam int CW = $clog2(MAX_DIM);

  logic [CW-1:0] col, row;
  logic [CW-1:0] min_col, max_col, min_row, max_row;
  logic [CW-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
  logic          seen, seen_next;
  logic [DIM_W-1:0] w, h, wc, hc;
  logic          accept, hit, col_last, row_last, frame_last;

  // out-of-range sizes clamp to 1 .. MAX_DIM
  always_comb begin
    wc = DIM_W'(mask_width);
    hc = DIM_W'(mask_height);
    if (wc == '0) begin
      w = DIM_W'(1);
    end else if (wc > DIM_W'(MAX_DIM)) begin
      w = DIM_W'(MAX_DIM);
    end else begin
      w = wc;
    end
    if (hc == '0) begin
      h = DIM_W'(1);
    end else if (hc > DIM_W'(MAX_DIM)) begin
      h = DIM_W'(MAX_DIM);
    end else begin
      h = hc;
    end
  end

  assign pixel_ready = !full;
  assign accept      = pixel_valid && !full;
  assign hit         = accept && pixel_set;
  assign col_last    = (DIM_W'(col) + DIM_W'(1)) >= w;
  assign row_last    = (DIM_W'(row) + DIM_W'(1)) >= h;
  assign frame_last  = col_last && row_last;
  assign push        = accept && frame_last && !restart;

  always_comb begin
    seen_next    = seen | hit;
    min_col_next = (hit && (!seen || col < min_col)) ? col : min_col;
    min_row_next = (hit && (!seen || row < min_row)) ? row : min_row;
    max_col_next = (hit && col > max_col) ? col : max_col;
    max_row_next = (hit && row > max_row) ? row : max_row;
  end

  // with no set pixel the near edges fall back to the frame size
  always_comb begin
    box.x1 = seen_next ? DIM_W'(min_col_next) : w;
    box.y1 = seen_next ? DIM_W'(min_row_next) : h;
    box.x2 = DIM_W'(max_col_next) + DIM_W'(1);
    box.y2 = DIM_W'(max_row_next) + DIM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col     <= '0;
      row     <= '0;
      seen    <= 1'b0;
      max_col <= '0;
      max_row <= '0;
    end else if (accept) begin
      if (frame_last) begin
        col     <= '0;
        row     <= '0;
        seen    <= 1'b0;
        max_col <= '0;
        max_row <= '0;
      end else begin
        if (col_last) begin
          col <= '0;
          row <= row + CW'(1);
        end else begin
          col <= col + CW'(1);
        end
        seen    <= seen_next;
        max_col <= max_col_next;
        max_row <= max_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_col <= min_col_next;
      min_row <= min_row_next;
    end
  end

endmodule

FILE: hdl/bbc_fifo.sv
// short box queue between the scanner and the world box pipeline
module bbc_fifo import bbc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  box_t din,
  output logic full,
  input  logic pop,
  output box_t dout,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  box_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: hdl/bbc_back.sv
// world box pipeline: scale multiply, then position add and saturation into the output register
module bbc_back import bbc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      empty,
  output logic                      pop,
  input  box_t                      box,
  output logic                      box_valid,
  input  logic                      box_ready,
  output logic [LOC_W-1:0]          local_x1,
  output logic [LOC_W-1:0]          local_y1,
  output logic [LOC_W-1:0]          local_x2,
  output logic [LOC_W-1:0]          local_y2,
  output logic signed [WORLD_W-1:0] world_x1,
  output logic signed [WORLD_W-1:0] world_y1,
  output logic signed [WORLD_W-1:0] world_x2,
  output logic signed [WORLD_W-1:0] world_y2
);

  logic              adv;
  logic              s1_valid;
  box_t              s1_box;
  logic [PROD_W-1:0] p_x1, p_y1, p_x2, p_y2;
  logic signed [WORLD_W-1:0] e_x1, e_y1, e_x2, e_y2;

  function automatic logic signed [WORLD_W-1:0] world_edge(
    input logic signed [POS_W-1:0] pos,
    input logic [PROD_W-1:0]       prod,
    input logic                    sub
  );
    logic signed [SUM_W-1:0] s;
    logic [PROD_W-1:0]       t;
    t = prod >> FRAC_BITS;
    s = $signed({{(SUM_W - POS_W){pos[POS_W-1]}}, pos})
      + $signed({2'b00, t})
      - $signed(SUM_W'(sub));
    return sat_world(s);
  endfunction

  assign adv = !box_valid || box_ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      box_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= !empty;
      box_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_box <= box;
      p_x1   <= PROD_W'(box.x1) * PROD_W'(cfg.scale_x);
      p_y1   <= PROD_W'(box.y1) * PROD_W'(cfg.scale_y);
      p_x2   <= PROD_W'(box.x2) * PROD_W'(cfg.scale_x);
      p_y2   <= PROD_W'(box.y2) * PROD_W'(cfg.scale_y);
    end
  end

  always_comb begin
    e_x1 = world_edge(cfg.pos_x, p_x1, 1'b0);
    e_y1 = world_edge(cfg.pos_y, p_y1, 1'b0);
    e_x2 = world_edge(cfg.pos_x, p_x2, 1'b1);
    e_y2 = world_edge(cfg.pos_y, p_y2, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      local_x1 <= s1_box.x1[LOC_W-1:0];
      local_y1 <= s1_box.y1[LOC_W-1:0];
      local_x2 <= s1_box.x2[LOC_W-1:0];
      local_y2 <= s1_box.y2[LOC_W-1:0];
      world_x1 <= cfg.collision_on ? e_x1 : '0;
      world_y1 <= cfg.collision_on ? e_y1 : '0;
      world_x2 <= cfg.collision_on ? e_x2 : '0;
      world_y2 <= cfg.collision_on ? e_y2 : '0;
    end
  end

endmodule

FILE: hdl/mask_bounding_box_collider.sv
// top level of the mask bounding box collider: config registers, scanner, box queue, world pipeline
// Takes one mask pixel request per clock in row-major order and, with the last pixel of each
// mask_width by mask_height frame, queues that frame's local box; the box result leaves
// through a multiply stage and an add/saturate stage into the output register. Frames run
// back to back at one pixel per cycle; pixel_ready drops only when the QUEUE_DEPTH entry box queue
// is full because the result side is stalled. Writing mask_width or mask_height restarts the scan.
module mask_bounding_box_collider import bbc_pkg::*; #(
  parameter int MAX_DIM     = 1024,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [DATA_W-1:0]         cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_ready,
  input  logic                      pixel_set,
  output logic                      box_valid,
  input  logic                      box_ready,
  output logic [LOC_W-1:0]          local_x1,
  output logic [LOC_W-1:0]          local_y1,
  output logic [LOC_W-1:0]          local_x2,
  output logic [LOC_W-1:0]          local_y2,
  output logic signed [WORLD_W-1:0] world_x1,
  output logic signed [WORLD_W-1:0] world_y1,
  output logic signed [WORLD_W-1:0] world_x2,
  output logic signed [WORLD_W-1:0] world_y2
);

  logic [LOC_W-1:0] mask_width, mask_height;
  cfg_t             cfg;
  logic             cfg_we, restart;
  logic             push, pop, full, empty;
  box_t             box_in, box_out;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == REG_MASK_WIDTH || cfg_index == REG_MASK_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width       <= LOC_W'(1024);
      mask_height      <= LOC_W'(1024);
      cfg.scale_x      <= SCALE_W'(65536);
      cfg.scale_y      <= SCALE_W'(65536);
      cfg.collision_on <= 1'b1;
      cfg.pos_x        <= '0;
      cfg.pos_y        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASK_WIDTH:   mask_width       <= cfg_data[LOC_W-1:0];
        REG_MASK_HEIGHT:  mask_height      <= cfg_data[LOC_W-1:0];
        REG_SCALE_X:      cfg.scale_x      <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:      cfg.scale_y      <= cfg_data[SCALE_W-1:0];
        REG_COLLISION_ON: cfg.collision_on <= cfg_data[0];
        REG_POS_X:        cfg.pos_x        <= $signed(cfg_data[POS_W-1:0]);
        REG_POS_Y:        cfg.pos_y        <= $signed(cfg_data[POS_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  bbc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .mask_width (mask_width),
    .mask_height(mask_height),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_set  (pixel_set),
    .full       (full),
    .push       (push),
    .box        (box_in)
  );

  bbc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (box_in),
    .full (full),
    .pop  (pop),
    .dout (box_out),
    .empty(empty)
  );

  bbc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop      (pop),
    .box      (box_out),
    .box_valid(box_valid),
    .box_ready(box_ready),
    .local_x1 (local_x1),
    .local_y1 (local_y1),
    .local_x2 (local_x2),
    .local_y2 (local_y2),
    .world_x1 (world_x1),
    .world_y1 (world_y1),
    .world_x2 (world_x2),
    .world_y2 (world_y2)
  );

endmodule
